### rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// Great-circle distance: shared package
// Fixed-point constants, the CORDIC arctangent table and common types.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 34;

   localparam int LAT_W    = 30;
   localparam int LON_W    = 31;
   localparam int RADIUS_W = 13;
   localparam int DIST_W   = 23;

   localparam logic [RADIUS_W-1:0] EARTH_RADIUS_KM = 13'd6370;
   localparam int                  DIAMETER_FACTOR = 2;
   localparam logic [DIST_W-1:0]   DIST_MAX        = 23'h7FFFFF;

   // Angles and unit values in Q30.
   localparam logic [33:0] Q30_ONE     = 34'd1073741824;
   localparam logic [33:0] Q30_HALF_PI = 34'd1686629713;
   localparam logic [33:0] Q30_PI      = 34'd3373259426;
   localparam logic [33:0] Q30_TWO_PI  = 34'd6746518852;
   localparam logic [33:0] Q30_GAIN    = 34'd652032874;

   localparam logic [31:0] ATAN_TABLE [10] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149
   };

   typedef logic signed [CORDIC_W-1:0] cordic_type;

   // Beyond the table the arctangent equals the shift weight less one LSB.
   function automatic logic [31:0] atan_q30(input int step);
      if (step < 10) begin
         return ATAN_TABLE[step[3:0]];
      end
      return (32'd1 << (30 - step)) - 32'd1;
   endfunction

endpackage

### rtl/great_circle_distance_core.sv
// ----------------------------------------------------------------------------
// Great-circle distance core
// Haversine distance between two points given in fixed-point radians.
// ----------------------------------------------------------------------------
// The core takes one request per clock cycle while req_stall is low and
// returns one distance per request, in order. The path runs through four
// parallel sine and cosine pipelines (range reduction and 30 CORDIC stages),
// three multiply stages, two pipelined square roots of 31 stages each, a
// 30-stage vectoring CORDIC for the arcsine and two scaling stages. A one-entry
// output buffer catches a result that is stalled at the output; the input and
// the pipeline stall only while that buffer holds a result. The radius register
// resets to 6370 km and is written through the csr port; the user must write it
// only while the core holds no request, as the core does not enforce this.
module great_circle_distance_core
   import gcd_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 28,
   parameter int DIST_FRAC_BITS  = 8
)(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [LAT_W-1:0]    req_start_lat,
   input  logic signed [LON_W-1:0]    req_start_lon,
   input  logic signed [LAT_W-1:0]    req_target_lat,
   input  logic signed [LON_W-1:0]    req_target_lon,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DIST_W-1:0]          rsp_distance_km_q8,

   input  logic                       csr_write_en,
   input  logic [RADIUS_W-1:0]        csr_write_data
);

   localparam int ANG_W      = 61 - ANGLE_FRAC_BITS;
   localparam int HALF_SHIFT = 29 - ANGLE_FRAC_BITS;
   localparam int FULL_SHIFT = 30 - ANGLE_FRAC_BITS;
   localparam int SQ_IN_W    = 62;
   localparam int SQ_OUT_W   = SQ_IN_W / 2;
   localparam int Q_DLY      = SQ_OUT_W + 2;
   localparam int Z_W        = 31;
   localparam int PROD_W     = RADIUS_W + 1 + Z_W;
   localparam int RND_W      = PROD_W + 1;

   localparam logic [SQ_IN_W-1:0] ONE_Q60   = SQ_IN_W'(1) << 60;
   localparam logic [RND_W-1:0]   RND_HALF  = RND_W'(1) << (29 - DIST_FRAC_BITS);

   logic en;

   // Configuration.
   logic [RADIUS_W-1:0] radius_ff;
   logic [RADIUS_W:0]   diam;

   // Input stage.
   logic signed [ANG_W-1:0] hdlat_in;
   logic signed [ANG_W-1:0] hdlon_in;
   logic signed [ANG_W-1:0] lat1_in;
   logic signed [ANG_W-1:0] lat2_in;
   logic                    in_v_ff;
   logic signed [ANG_W-1:0] hdlat_ff;
   logic signed [ANG_W-1:0] hdlon_ff;
   logic signed [ANG_W-1:0] lat1_ff;
   logic signed [ANG_W-1:0] lat2_ff;

   // Trigonometry results.
   logic       sc_v;
   cordic_type sin_dlat;
   cordic_type sin_dlon;
   cordic_type cos_lat1;
   cordic_type cos_lat2;

   // Haversine sum.
   logic signed [31:0] s_dlat32;
   logic signed [31:0] s_dlon32;
   logic signed [31:0] c1_32;
   logic signed [31:0] c2_32;
   logic signed [63:0] sq_dlat;
   logic signed [63:0] sq_dlon;
   logic signed [63:0] cc_prod;
   logic signed [63:0] p_prod;
   logic signed [33:0] a_sum;
   logic               m1_v_ff;
   logic               m2_v_ff;
   logic               m3_v_ff;
   logic [30:0]        hlat_ff;
   logic [30:0]        hlon_ff;
   logic signed [31:0] cc_ff;
   logic [30:0]        hlat2_ff;
   logic signed [32:0] p_ff;
   logic [30:0]        a_ff;

   // Square roots.
   logic                q_v;
   logic [SQ_OUT_W-1:0] q_root;
   logic [SQ_IN_W-1:0]  qq;
   logic                q1_v_ff;
   logic                q2_v_ff;
   logic [SQ_IN_W-1:0]  qq_ff;
   logic [SQ_IN_W-1:0]  r2_ff;
   logic [SQ_OUT_W-1:0] q_dly_ff [0:Q_DLY-1];
   logic                cq_v;
   logic [SQ_OUT_W-1:0] cq_root;

   // Arcsine by vectoring CORDIC.
   logic       vec_v_ff [0:CORDIC_STEPS];
   cordic_type vec_x_ff [0:CORDIC_STEPS];
   cordic_type vec_y_ff [0:CORDIC_STEPS];
   cordic_type vec_z_ff [0:CORDIC_STEPS];

   // Scaling and output.
   logic [Z_W-1:0]    z_clamp;
   logic              d1_v_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [RND_W-1:0]  rnd_sum;
   logic [RND_W-1:0]  scaled;
   logic              out_v_ff;
   logic [DIST_W-1:0] out_d_ff;
   logic              skid_v_ff;
   logic [DIST_W-1:0] skid_d_ff;

   // The whole pipeline moves unless the output buffer is holding a result.
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= EARTH_RADIUS_KM;
      end else if (csr_write_en) begin
         radius_ff <= csr_write_data;
      end
   end

   assign diam = (RADIUS_W + 1)'(radius_ff * DIAMETER_FACTOR);

   // Half differences and latitudes, all in Q30.
   assign hdlat_in = (ANG_W'(req_target_lat) - ANG_W'(req_start_lat)) <<< HALF_SHIFT;
   assign hdlon_in = (ANG_W'(req_target_lon) - ANG_W'(req_start_lon)) <<< HALF_SHIFT;
   assign lat1_in  = ANG_W'(req_start_lat) <<< FULL_SHIFT;
   assign lat2_in  = ANG_W'(req_target_lat) <<< FULL_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hdlat_ff <= hdlat_in;
         hdlon_ff <= hdlon_in;
         lat1_ff  <= lat1_in;
         lat2_ff  <= lat2_in;
      end
   end

   gcd_sincos #(.ANG_W(ANG_W)) u_sc_dlat (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (in_v_ff),
      .ang_i   (hdlat_ff),
      .valid_o (),
      .sin_o   (sin_dlat),
      .cos_o   ()
   );

   gcd_sincos #(.ANG_W(ANG_W)) u_sc_dlon (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (in_v_ff),
      .ang_i   (hdlon_ff),
      .valid_o (),
      .sin_o   (sin_dlon),
      .cos_o   ()
   );

   gcd_sincos #(.ANG_W(ANG_W)) u_sc_lat1 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (in_v_ff),
      .ang_i   (lat1_ff),
      .valid_o (sc_v),
      .sin_o   (),
      .cos_o   (cos_lat1)
   );

   gcd_sincos #(.ANG_W(ANG_W)) u_sc_lat2 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (in_v_ff),
      .ang_i   (lat2_ff),
      .valid_o (),
      .sin_o   (),
      .cos_o   (cos_lat2)
   );

   // CORDIC outputs stay within about one unit, so 32 bits hold them.
   assign s_dlat32 = 32'(sin_dlat);
   assign s_dlon32 = 32'(sin_dlon);
   assign c1_32    = 32'(cos_lat1);
   assign c2_32    = 32'(cos_lat2);
   assign sq_dlat  = s_dlat32 * s_dlat32;
   assign sq_dlon  = s_dlon32 * s_dlon32;
   assign cc_prod  = c1_32 * c2_32;
   assign p_prod   = cc_ff * signed'({1'b0, hlon_ff});
   assign a_sum    = signed'({3'b000, hlat2_ff}) + 34'(p_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= sc_v;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hlat_ff  <= sq_dlat[60:30];
         hlon_ff  <= sq_dlon[60:30];
         cc_ff    <= cc_prod[61:30];
         hlat2_ff <= hlat_ff;
         p_ff     <= p_prod[62:30];
         priority if (a_sum[33]) begin
            a_ff <= '0;
         end else if (34'(a_sum) > Q30_ONE) begin
            a_ff <= Q30_ONE[30:0];
         end else begin
            a_ff <= a_sum[30:0];
         end
      end
   end

   gcd_isqrt #(.IN_W(SQ_IN_W)) u_sqrt_q (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (m3_v_ff),
      .rad_i   ({1'b0, a_ff, 30'd0}),
      .valid_o (q_v),
      .root_o  (q_root)
   );

   assign qq = q_root * q_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_v_ff <= 1'b0;
         q2_v_ff <= 1'b0;
      end else if (en) begin
         q1_v_ff <= q_v;
         q2_v_ff <= q1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qq_ff <= qq;
         r2_ff <= ONE_Q60 - qq_ff;
      end
   end

   // The sine of the half angle waits here for its cosine.
   always_ff @(posedge clock) begin
      if (en) begin
         q_dly_ff[0] <= q_root;
      end
   end

   for (genvar k = 1; k < Q_DLY; k++) begin : g_qdly
      always_ff @(posedge clock) begin
         if (en) begin
            q_dly_ff[k] <= q_dly_ff[k-1];
         end
      end
   end

   gcd_isqrt #(.IN_W(SQ_IN_W)) u_sqrt_c (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (q2_v_ff),
      .rad_i   (r2_ff),
      .valid_o (cq_v),
      .root_o  (cq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_v_ff[0] <= 1'b0;
      end else if (en) begin
         vec_v_ff[0] <= cq_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_x_ff[0] <= cordic_type'({3'b000, cq_root});
         vec_y_ff[0] <= cordic_type'({3'b000, q_dly_ff[Q_DLY-1]});
         vec_z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      localparam cordic_type ATAN_I = cordic_type'({2'b00, atan_q30(i)});
      logic back;

      assign back = !vec_y_ff[i][CORDIC_W-1] && (vec_y_ff[i] != '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            vec_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            vec_v_ff[i+1] <= vec_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (back) begin
               vec_x_ff[i+1] <= vec_x_ff[i] + (vec_y_ff[i] >>> i);
               vec_y_ff[i+1] <= vec_y_ff[i] - (vec_x_ff[i] >>> i);
               vec_z_ff[i+1] <= vec_z_ff[i] + ATAN_I;
            end else begin
               vec_x_ff[i+1] <= vec_x_ff[i] - (vec_y_ff[i] >>> i);
               vec_y_ff[i+1] <= vec_y_ff[i] + (vec_x_ff[i] >>> i);
               vec_z_ff[i+1] <= vec_z_ff[i] - ATAN_I;
            end
         end
      end
   end

   assign z_clamp = vec_z_ff[CORDIC_STEPS][CORDIC_W-1] ? '0
                                                        : vec_z_ff[CORDIC_STEPS][Z_W-1:0];
   assign rnd_sum = RND_W'(prod_ff) + RND_HALF;
   assign scaled  = rnd_sum >> (30 - DIST_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         d1_v_ff  <= vec_v_ff[CORDIC_STEPS];
         out_v_ff <= d1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= PROD_W'(diam) * PROD_W'(z_clamp);
         out_d_ff <= (scaled > RND_W'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
      end
   end

   // A result that is stalled at the output is parked in the buffer so that
   // the pipeline behind it can move into the output register before it stops.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         skid_v_ff <= rsp_stall;
      end else begin
         skid_v_ff <= out_v_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_d_ff <= out_d_ff;
      end
   end

   assign rsp_valid          = skid_v_ff || out_v_ff;
   assign rsp_distance_km_q8 = skid_v_ff ? skid_d_ff : out_d_ff;

`ifndef SYNTHESIS
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && rsp_stall))
      else $error("output buffer filled without a stalled result");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_stall) |=> (skid_v_ff && $stable(skid_d_ff) && $stable(out_d_ff)))
      else $error("buffered result or frozen pipeline changed under stall");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_stall && out_v_ff) |=>
         (rsp_valid && (rsp_distance_km_q8 == $past(out_d_ff))))
      else $error("result behind the buffer lost after drain");

   a_stall_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(in_v_ff) && $stable(out_v_ff))
      else $error("pipeline advanced while output buffer full");
`endif

endmodule

### rtl/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// Great-circle distance: pipelined integer square root
// Restoring floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module gcd_isqrt
   import gcd_pkg::*;
#(
   parameter int IN_W = 62
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  valid_i,
   input  logic [IN_W-1:0]       rad_i,
   output logic                  valid_o,
   output logic [IN_W/2-1:0]     root_o
);

   localparam int OUT_W = IN_W / 2;
   localparam int REM_W = OUT_W + 2;

   logic             v_ff    [1:OUT_W];
   logic [REM_W-1:0] rem_ff  [1:OUT_W];
   logic [OUT_W-1:0] root_ff [1:OUT_W];
   logic [IN_W-1:0]  rest_ff [1:OUT_W];

   for (genvar j = 0; j < OUT_W; j++) begin : g_step
      logic             prev_v;
      logic [REM_W-1:0] prev_rem;
      logic [OUT_W-1:0] prev_root;
      logic [IN_W-1:0]  prev_rest;
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;

      if (j == 0) begin : g_first
         assign prev_v    = valid_i;
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_rest = rad_i;
      end else begin : g_next
         assign prev_v    = v_ff[j];
         assign prev_rem  = rem_ff[j];
         assign prev_root = root_ff[j];
         assign prev_rest = rest_ff[j];
      end

      assign cur   = {prev_rem[REM_W-3:0], prev_rest[IN_W-1:IN_W-2]};
      assign trial = {prev_root, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rest_ff[j+1] <= prev_rest << 2;
            if (cur >= trial) begin
               rem_ff[j+1]  <= cur - trial;
               root_ff[j+1] <= {prev_root[OUT_W-2:0], 1'b1};
            end else begin
               rem_ff[j+1]  <= cur;
               root_ff[j+1] <= {prev_root[OUT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign valid_o = v_ff[OUT_W];
   assign root_o  = root_ff[OUT_W];

endmodule

### rtl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// Great-circle distance: pipelined sine and cosine
// Range reduction to [-pi/2, pi/2] followed by a 30-stage rotation CORDIC.
// ----------------------------------------------------------------------------
module gcd_sincos
   import gcd_pkg::*;
#(
   parameter int ANG_W = 33
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    valid_i,
   input  logic signed [ANG_W-1:0] ang_i,
   output logic                    valid_o,
   output cordic_type              sin_o,
   output cordic_type              cos_o
);

   localparam int MW        = (ANG_W > 34) ? ANG_W : 34;
   localparam int RED_STEPS = (ANG_W > 33) ? ANG_W - 33 : 1;

   logic [ANG_W-1:0] ang_mag;

   logic          red_v_ff   [0:RED_STEPS];
   logic          red_neg_ff [0:RED_STEPS];
   logic [MW-1:0] red_mag_ff [0:RED_STEPS];

   logic [33:0] rem;
   logic        fold_v_ff;
   logic        fold_neg_ff;
   logic [33:0] fold_m_ff;
   logic        refl_v_ff;
   logic        refl_neg_ff;
   logic        refl_flip_ff;
   logic [33:0] refl_m_ff;

   logic       cor_v_ff    [0:CORDIC_STEPS];
   logic       cor_flip_ff [0:CORDIC_STEPS];
   cordic_type cor_x_ff    [0:CORDIC_STEPS];
   cordic_type cor_y_ff    [0:CORDIC_STEPS];
   cordic_type cor_z_ff    [0:CORDIC_STEPS];

   logic       out_v_ff;
   cordic_type sin_ff;
   cordic_type cos_ff;

   // The remainder is taken on the magnitude, then given the sign of the angle.
   assign ang_mag = ang_i[ANG_W-1] ? unsigned'(-ang_i) : unsigned'(ang_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         red_v_ff[0] <= 1'b0;
      end else if (en) begin
         red_v_ff[0] <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_neg_ff[0] <= ang_i[ANG_W-1];
         red_mag_ff[0] <= MW'(ang_mag);
      end
   end

   for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
      localparam logic [MW-1:0] STEP_SUB = MW'(Q30_TWO_PI) << (RED_STEPS - 1 - j);

      always_ff @(posedge clock) begin
         if (reset) begin
            red_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            red_v_ff[j+1] <= red_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            red_neg_ff[j+1] <= red_neg_ff[j];
            red_mag_ff[j+1] <= (red_mag_ff[j] >= STEP_SUB) ? red_mag_ff[j] - STEP_SUB
                                                            : red_mag_ff[j];
         end
      end
   end

   assign rem = red_mag_ff[RED_STEPS][33:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_v_ff <= 1'b0;
         refl_v_ff <= 1'b0;
      end else if (en) begin
         fold_v_ff <= red_v_ff[RED_STEPS];
         refl_v_ff <= fold_v_ff;
      end
   end

   // Fold into [-pi, pi], then reflect about +-pi/2, which negates the cosine.
   always_ff @(posedge clock) begin
      if (en) begin
         if (rem > Q30_PI) begin
            fold_m_ff   <= Q30_TWO_PI - rem;
            fold_neg_ff <= !red_neg_ff[RED_STEPS];
         end else begin
            fold_m_ff   <= rem;
            fold_neg_ff <= red_neg_ff[RED_STEPS];
         end
         refl_neg_ff <= fold_neg_ff;
         if (fold_m_ff > Q30_HALF_PI) begin
            refl_m_ff    <= Q30_PI - fold_m_ff;
            refl_flip_ff <= 1'b1;
         end else begin
            refl_m_ff    <= fold_m_ff;
            refl_flip_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_v_ff[0] <= 1'b0;
      end else if (en) begin
         cor_v_ff[0] <= refl_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cor_flip_ff[0] <= refl_flip_ff;
         cor_x_ff[0]    <= cordic_type'(Q30_GAIN);
         cor_y_ff[0]    <= '0;
         cor_z_ff[0]    <= refl_neg_ff ? -cordic_type'(refl_m_ff) : cordic_type'(refl_m_ff);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam cordic_type ATAN_I = cordic_type'({2'b00, atan_q30(i)});
      logic fwd;

      assign fwd = !cor_z_ff[i][CORDIC_W-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            cor_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            cor_v_ff[i+1] <= cor_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cor_flip_ff[i+1] <= cor_flip_ff[i];
            if (fwd) begin
               cor_x_ff[i+1] <= cor_x_ff[i] - (cor_y_ff[i] >>> i);
               cor_y_ff[i+1] <= cor_y_ff[i] + (cor_x_ff[i] >>> i);
               cor_z_ff[i+1] <= cor_z_ff[i] - ATAN_I;
            end else begin
               cor_x_ff[i+1] <= cor_x_ff[i] + (cor_y_ff[i] >>> i);
               cor_y_ff[i+1] <= cor_y_ff[i] - (cor_x_ff[i] >>> i);
               cor_z_ff[i+1] <= cor_z_ff[i] + ATAN_I;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= cor_v_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= cor_y_ff[CORDIC_STEPS];
         cos_ff <= cor_flip_ff[CORDIC_STEPS] ? -cor_x_ff[CORDIC_STEPS]
                                             : cor_x_ff[CORDIC_STEPS];
      end
   end

   assign valid_o = out_v_ff;
   assign sin_o   = sin_ff;
   assign cos_o   = cos_ff;

endmodule
